// ----- sv/fss_pkg.sv -----
package fss_pkg;

   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int PAT_LEN_W   = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_FIRST  = 2'd0,
      CSR_PATTERN_LAST   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2
   } csr_index_type;

   localparam logic [7:0] SCORE_PREFIX    = 8'd100;
   localparam logic [7:0] SCORE_SUBSTRING = 8'd50;
   localparam logic [7:0] SCORE_STREAK    = 8'd5;
   localparam logic [7:0] SCORE_HIT       = 8'd1;
   localparam logic [7:0] SCORE_BOUNDARY  = 8'd10;

   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5a;
   localparam logic [7:0] CHAR_CASE_SHIFT = 8'h20;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_DASH       = 8'h2d;
   localparam logic [7:0] CHAR_GREATER    = 8'h3e;
   localparam logic [7:0] CHAR_SLASH      = 8'h2f;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic       matched;
      logic [7:0] score;
   } rsp_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       separator;
      logic       last;
   } char_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CHAR_CASE_SHIFT;
      end
      return r;
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_UNDERSCORE) || (c == CHAR_DASH) ||
             (c == CHAR_GREATER) || (c == CHAR_SLASH);
   endfunction

endpackage

// ----- sv/fuzzy_subsequence_scorer_core.sv -----
// fuzzy subsequence scorer
// scores a text, one ascii byte per word, against a pattern of up to PATTERN_MAX chars
// request queue: drive req_data and raise req_push; the word is taken on an edge with
//   req_full low; mark the final char of each text with last_char
// response queue: one word per text; while rsp_empty is low rsp_data holds the oldest
//   result, taken on an edge with rsp_pop high
// csr port: csr_write with csr_index 0/1 loads pattern bytes 0-7 / 8-15, index 2 loads
//   the pattern length; write only while no text is in flight
// throughput: one char per cycle, set by the single-cycle window compare and score
//   update in the back end
// latency: a last char taken at edge t gives a result visible after edge t+1
//   (one cycle in the char queue; scoring feeds the response queue directly)
// stall: when the response queue fills, the scoring stage holds on the next last char;
//   the char queue then fills and req_full rises, no word is dropped
// reset: empties both queues, clears pattern registers and per-text state
module fuzzy_subsequence_scorer_core #(
   parameter int PATTERN_MAX = fss_pkg::PATTERN_MAX_DEFAULT,
   parameter int QUEUE_DEPTH = fss_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  fss_pkg::req_type                req_data,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output fss_pkg::rsp_type                rsp_data,
   input  logic                            csr_write,
   input  logic [fss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fss_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic              char_valid;
   logic              char_ready;
   fss_pkg::char_type char_word;
   logic              result_push;
   logic              result_full;
   fss_pkg::rsp_type  result_word;

   fss_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .out_valid (char_valid),
      .out_word  (char_word),
      .out_ready (char_ready)
   );

   fss_back #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_valid  (char_valid),
      .in_word   (char_word),
      .in_ready  (char_ready),
      .out_push  (result_push),
      .out_word  (result_word),
      .out_full  (result_full)
   );

   fss_fifo #(
      .WIDTH ($bits(fss_pkg::rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (result_push),
      .data_in  (result_word),
      .full     (result_full),
      .pop      (rsp_pop),
      .data_out (rsp_data),
      .empty    (rsp_empty)
   );

endmodule

// ----- sv/fss_fifo.sv -----
module fss_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = fss_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ----- sv/fss_front.sv -----
module fss_front #(
   parameter int QUEUE_DEPTH = fss_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  fss_pkg::req_type   req_data,
   output logic               req_full,
   output logic               out_valid,
   output fss_pkg::char_type  out_word,
   input  logic               out_ready
);

   fss_pkg::char_type classed;
   logic              queue_empty;

   // fold case and tag separators before queueing
   always_comb begin
      classed.ch        = fss_pkg::fold(req_data.text_char);
      classed.separator = fss_pkg::is_separator(classed.ch);
      classed.last      = req_data.last_char;
   end

   fss_fifo #(
      .WIDTH ($bits(fss_pkg::char_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_char_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .data_in  (classed),
      .full     (req_full),
      .pop      (out_ready),
      .data_out (out_word),
      .empty    (queue_empty)
   );

   assign out_valid = !queue_empty;

endmodule

// ----- sv/fss_back.sv -----
module fss_back #(
   parameter int PATTERN_MAX = fss_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [fss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fss_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               in_valid,
   input  fss_pkg::char_type                  in_word,
   output logic                               in_ready,
   output logic                               out_push,
   output fss_pkg::rsp_type                   out_word,
   input  logic                               out_full
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
   localparam logic [fss_pkg::PAT_LEN_W-1:0] LEN_MAX_CSR = fss_pkg::PAT_LEN_W'(PATTERN_MAX);

   logic [fss_pkg::CSR_DATA_W-1:0] pattern_first_ff;
   logic [fss_pkg::CSR_DATA_W-1:0] pattern_last_ff;
   logic [fss_pkg::PAT_LEN_W-1:0]  pattern_length_ff;
   logic [2*fss_pkg::CSR_DATA_W-1:0] pattern_all;
   logic [7:0]       pat [PATTERN_MAX];
   logic [LEN_W-1:0] len;

   logic [7:0]       recent_ff [PATTERN_MAX];
   logic [7:0]       win [PATTERN_MAX];
   logic [LEN_W-1:0] chars_seen_ff, chars_seen_in;
   logic             substring_seen_ff, substring_seen_in;
   logic             prefix_seen_ff, prefix_seen_in;
   logic [LEN_W-1:0] next_pos_ff, next_pos_in;
   logic [7:0]       running_score_ff, running_score_in;
   logic             previous_hit_ff, previous_hit_in;
   logic             at_boundary_ff, at_boundary_in;

   logic             take;
   logic [LEN_W:0]   seen_plus;
   logic             sub_hit;
   logic [LEN_W-1:0] j;
   logic [7:0]       pat_next;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_first_ff  <= '0;
         pattern_last_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            fss_pkg::CSR_PATTERN_FIRST:  pattern_first_ff  <= csr_data;
            fss_pkg::CSR_PATTERN_LAST:   pattern_last_ff   <= csr_data;
            fss_pkg::CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[fss_pkg::PAT_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern_all = {pattern_last_ff, pattern_first_ff};

   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         pat[k] = fss_pkg::fold(pattern_all[8*k +: 8]);
      end
   end

   assign len = (pattern_length_ff > LEN_MAX_CSR) ? LEN_MAX : pattern_length_ff[LEN_W-1:0];

   assign in_ready = !(in_word.last && out_full);
   assign take     = in_valid && in_ready;
   assign out_push = take && in_word.last;

   always_comb begin
      win[0] = in_word.ch;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win[k] = recent_ff[k-1];
      end
   end

   always_comb begin
      chars_seen_in     = chars_seen_ff;
      substring_seen_in = substring_seen_ff;
      prefix_seen_in    = prefix_seen_ff;
      next_pos_in       = next_pos_ff;
      running_score_in  = running_score_ff;
      previous_hit_in   = previous_hit_ff;
      at_boundary_in    = in_word.separator;
      j                 = '0;

      if (chars_seen_ff != LEN_MAX) begin
         chars_seen_in = chars_seen_ff + LEN_W'(1);
      end

      // substring ending at this character
      seen_plus = {1'b0, chars_seen_ff} + (LEN_W+1)'(1);
      sub_hit   = (len != '0) && (seen_plus >= {1'b0, len});
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (LEN_W'(i) < len) begin
            j = len - LEN_W'(i) - LEN_W'(1);
            if (win[j[IDX_W-1:0]] != pat[i]) begin
               sub_hit = 1'b0;
            end
         end
      end
      if (sub_hit) begin
         substring_seen_in = 1'b1;
         if (seen_plus == {1'b0, len}) begin
            prefix_seen_in = 1'b1;
         end
      end

      // greedy subsequence
      pat_next = pat[next_pos_ff[IDX_W-1:0]];
      if (next_pos_ff < len) begin
         if (in_word.ch == pat_next) begin
            next_pos_in      = next_pos_ff + LEN_W'(1);
            running_score_in = running_score_ff +
                               (previous_hit_ff ? fss_pkg::SCORE_STREAK : fss_pkg::SCORE_HIT) +
                               (at_boundary_ff ? fss_pkg::SCORE_BOUNDARY : 8'd0);
            previous_hit_in  = 1'b1;
         end else begin
            previous_hit_in  = 1'b0;
         end
      end

      if (len == '0) begin
         out_word.matched = 1'b1;
         out_word.score   = 8'd0;
      end else if (substring_seen_in) begin
         out_word.matched = 1'b1;
         out_word.score   = prefix_seen_in ? fss_pkg::SCORE_PREFIX : fss_pkg::SCORE_SUBSTRING;
      end else if (next_pos_in == len) begin
         out_word.matched = 1'b1;
         out_word.score   = running_score_in;
      end else begin
         out_word.matched = 1'b0;
         out_word.score   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_word.last)) begin
         chars_seen_ff     <= '0;
         substring_seen_ff <= 1'b0;
         prefix_seen_ff    <= 1'b0;
         next_pos_ff       <= '0;
         running_score_ff  <= '0;
         previous_hit_ff   <= 1'b0;
         at_boundary_ff    <= 1'b1;
      end else if (take) begin
         chars_seen_ff     <= chars_seen_in;
         substring_seen_ff <= substring_seen_in;
         prefix_seen_ff    <= prefix_seen_in;
         next_pos_ff       <= next_pos_in;
         running_score_ff  <= running_score_in;
         previous_hit_ff   <= previous_hit_in;
         at_boundary_ff    <= at_boundary_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int k = 0; k < PATTERN_MAX; k++) begin
            recent_ff[k] <= win[k];
         end
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && in_word.last) |=> (chars_seen_ff == '0 && next_pos_ff == '0 && at_boundary_ff))
      else $error("per-text state not cleared after last word");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      chars_seen_ff <= LEN_MAX)
      else $error("chars_seen past saturation");

   a_prefix_implies_sub: assert property (@(posedge clock) disable iff (reset)
      prefix_seen_ff |-> substring_seen_ff)
      else $error("prefix flagged without substring");

   a_no_score_without_hit: assert property (@(posedge clock) disable iff (reset)
      (next_pos_ff == '0) |-> (running_score_ff == '0 && !previous_hit_ff))
      else $error("score without any hit");

   a_unmatched_zero: assert property (@(posedge clock) disable iff (reset)
      (out_push && !out_word.matched) |-> (out_word.score == 8'd0))
      else $error("nonzero score on unmatched result");

endmodule

// ----- dv/fuzzy_subsequence_scorer_core_test.sv -----
`timescale 1ns / 100ps

module fuzzy_subsequence_scorer_core_test;

   localparam int PAT_MAX        = fss_pkg::PATTERN_MAX_DEFAULT;
   localparam int ITEM_TARGET    = 1750;
   localparam int PHASE_WORDS    = 100;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRINT_LIMIT    = 50;

   // expected match results, tracked per text
   class match_score_tracker;
      logic [63:0]      pat_low;
      logic [63:0]      pat_high;
      logic [4:0]       pat_len;
      logic [7:0]       window [PAT_MAX];
      int               seen;
      bit               found_substring;
      bit               found_prefix;
      int               next_pos;
      logic [7:0]       run_score;
      bit               prev_hit;
      bit               boundary;
      fss_pkg::rsp_type expected_results [$];
      int               errors;

      function new();
         errors   = 0;
         pat_low  = '0;
         pat_high = '0;
         pat_len  = '0;
         clear_text();
      endfunction

      function void clear_text();
         foreach (window[i]) window[i] = '0;
         seen            = 0;
         found_substring = 1'b0;
         found_prefix    = 1'b0;
         next_pos        = 0;
         run_score       = '0;
         prev_hit        = 1'b0;
         boundary        = 1'b1;
      endfunction

      function void write_reg(fss_pkg::csr_index_type idx, logic [63:0] value);
         case (idx)
            fss_pkg::CSR_PATTERN_FIRST: begin
               pat_low = value;
            end
            fss_pkg::CSR_PATTERN_LAST: begin
               pat_high = value;
            end
            fss_pkg::CSR_PATTERN_LENGTH: begin
               pat_len = value[fss_pkg::PAT_LEN_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [7:0] to_lower(logic [7:0] b);
         if (b >= fss_pkg::CHAR_UPPER_A && b <= fss_pkg::CHAR_UPPER_Z) begin
            return b + fss_pkg::CHAR_CASE_SHIFT;
         end
         return b;
      endfunction

      function logic [7:0] pat_char(int k);
         if (k < 8) begin
            return to_lower(pat_low[8*k +: 8]);
         end
         return to_lower(pat_high[8*(k-8) +: 8]);
      endfunction

      function bit splits_words(logic [7:0] b);
         return b == fss_pkg::CHAR_SPACE || b == fss_pkg::CHAR_UNDERSCORE ||
                b == fss_pkg::CHAR_DASH || b == fss_pkg::CHAR_GREATER ||
                b == fss_pkg::CHAR_SLASH;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void take_char(fss_pkg::req_type w);
         logic [7:0]       c;
         int               len;
         int               old_seen;
         bit               hit;
         fss_pkg::rsp_type r;
         c = to_lower(w.text_char);
         len = (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
         old_seen = seen;
         for (int i = PAT_MAX - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = c;
         if (seen < PAT_MAX) seen++;
         if (len > 0 && old_seen + 1 >= len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
               if (window[len-1-i] != pat_char(i)) hit = 1'b0;
            end
            if (hit) begin
               found_substring = 1'b1;
               if (old_seen + 1 == len) found_prefix = 1'b1;
            end
         end
         if (next_pos < len) begin
            if (c == pat_char(next_pos)) begin
               next_pos++;
               run_score = run_score + (prev_hit ? fss_pkg::SCORE_STREAK : fss_pkg::SCORE_HIT);
               if (boundary) run_score = run_score + fss_pkg::SCORE_BOUNDARY;
               prev_hit = 1'b1;
            end else begin
               prev_hit = 1'b0;
            end
         end
         boundary = splits_words(c);
         if (w.last_char) begin
            if (len == 0) begin
               r.matched = 1'b1;
               r.score   = '0;
            end else if (found_substring) begin
               r.matched = 1'b1;
               r.score   = found_prefix ? fss_pkg::SCORE_PREFIX : fss_pkg::SCORE_SUBSTRING;
            end else if (next_pos == len) begin
               r.matched = 1'b1;
               r.score   = run_score;
            end else begin
               r.matched = 1'b0;
               r.score   = '0;
            end
            expected_results.insert(expected_results.size(), r);
            clear_text();
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
      endtask

      task compare_result(fss_pkg::rsp_type got);
         fss_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected word matched=%0b score=%0d", got.matched, got.score));
            return;
         end
         want = expected_results.pop_front();
         if (got.matched !== want.matched) begin
            report($sformatf("matched got %0b want %0b", got.matched, want.matched));
         end
         if (got.score !== want.score) begin
            report($sformatf("score got %0d want %0d", got.score, want.score));
         end
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_push;
   fss_pkg::req_type                req_data;
   logic                            req_full;
   logic                            rsp_empty;
   logic                            rsp_pop;
   fss_pkg::rsp_type                rsp_data;
   logic                            csr_write;
   logic [fss_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [fss_pkg::CSR_DATA_W-1:0]  csr_data;

   match_score_tracker scorer = new();

   bit           hold_request = 1'b0;
   bit           draining     = 1'b0;
   int           burst_left   = 0;
   int           max_gap      = 4;
   int           accepted_words = 0;
   int           idle_cycles  = 0;
   logic [127:0] cur_pattern;
   logic [4:0]   cur_len;
   logic [7:0]   text_bytes [$];
   string        alphabet = "abcxyzABCXYZ09_- >/";

   fuzzy_subsequence_scorer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // receiver: rotating stall pattern, plus one long hold-off on request
   initial begin
      logic [7:0] pop_pattern;
      int         pop_count;
      rsp_pop = 1'b0;
      pop_pattern = 8'hff;
      pop_count = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (pop_count == 0) begin
            pop_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
            pop_count = 32;
         end
         pop_count--;
         rsp_pop = draining | pop_pattern[0];
         pop_pattern = {pop_pattern[0], pop_pattern[7:1]};
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) scorer.compare_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL fuzzy_subsequence_scorer_core");
         $finish;
      end
   end

   task send_word(fss_pkg::req_type w);
      @(negedge clock);
      req_push = 1'b1;
      req_data = w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      scorer.take_char(w);
      accepted_words++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_push = 1'b0;
         repeat ($urandom_range(0, max_gap)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task send_text(string s, bit close);
      fss_pkg::req_type w;
      for (int i = 0; i < s.len(); i++) begin
         w.text_char = s[i];
         w.last_char = close && (i == s.len() - 1);
         send_word(w);
      end
   endtask

   task send_bytes();
      fss_pkg::req_type w;
      for (int i = 0; i < text_bytes.size(); i++) begin
         w.text_char = text_bytes[i];
         w.last_char = (i == text_bytes.size() - 1);
         send_word(w);
      end
   endtask

   task wait_idle();
      @(negedge clock);
      req_push = 1'b0;
      while (scorer.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_csr(fss_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(negedge clock);
      csr_write = 1'b0;
      scorer.write_reg(idx, value);
   endtask

   task load_pattern(logic [127:0] bytes, logic [4:0] len);
      wait_idle();
      cur_pattern = bytes;
      cur_len = len;
      write_csr(fss_pkg::CSR_PATTERN_FIRST, bytes[63:0]);
      write_csr(fss_pkg::CSR_PATTERN_LAST, bytes[127:64]);
      write_csr(fss_pkg::CSR_PATTERN_LENGTH, 64'(len));
   endtask

   function automatic logic [127:0] pack_chars(string s);
      logic [127:0] r;
      r = '0;
      for (int i = 0; i < s.len() && i < PAT_MAX; i++) r[8*i +: 8] = s[i];
      return r;
   endfunction

   function automatic logic [7:0] filler();
      return alphabet[$urandom_range(0, alphabet.len() - 1)];
   endfunction

   function automatic void append_byte(logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   function automatic logic [7:0] mix_case(logic [7:0] b);
      if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) && $urandom_range(0, 1)) begin
         return b ^ fss_pkg::CHAR_CASE_SHIFT;
      end
      return b;
   endfunction

   task pick_config(int p);
      logic [127:0] bytes;
      logic [4:0]   len;
      int           r;
      r = $urandom_range(0, 7);
      case (p)
         0: len = 5'd16;
         1: len = 5'd0;
         2: len = 5'd31;
         3: len = 5'd1;
         4: len = 5'd16;
         default: begin
            if (r == 0) len = 5'd0;
            else if (r == 1) len = 5'($urandom_range(17, 31));
            else if (r <= 3) len = 5'($urandom_range(1, 16));
            else len = 5'($urandom_range(1, 5));
         end
      endcase
      if (p == 4) begin
         bytes = '1;
      end else if ($urandom_range(0, 3) == 0) begin
         bytes = {$urandom, $urandom, $urandom, $urandom};
      end else begin
         for (int k = 0; k < PAT_MAX; k++) bytes[8*k +: 8] = filler();
      end
      max_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      load_pattern(bytes, len);
   endtask

   task make_text();
      int ul;
      int mode;
      int skip;
      ul = (cur_len > PAT_MAX) ? PAT_MAX : int'(cur_len);
      text_bytes.delete();
      mode = $urandom_range(0, 11);
      skip = -1;
      if (mode <= 2) begin
         for (int k = 0; k < ul; k++) append_byte(mix_case(cur_pattern[8*k +: 8]));
         repeat ($urandom_range(0, 4)) append_byte(filler());
      end else if (mode <= 4) begin
         repeat ($urandom_range(1, 4)) append_byte(filler());
         for (int k = 0; k < ul; k++) append_byte(mix_case(cur_pattern[8*k +: 8]));
         repeat ($urandom_range(0, 3)) append_byte(filler());
      end else if (mode <= 8) begin
         // subsequence, with one char dropped in the broken variant
         if (mode == 8 && ul > 0) skip = $urandom_range(0, ul - 1);
         for (int k = 0; k < ul; k++) begin
            repeat ($urandom_range(0, 2)) append_byte(filler());
            if (k != skip) append_byte(mix_case(cur_pattern[8*k +: 8]));
         end
         repeat ($urandom_range(0, 2)) append_byte(filler());
      end else if (mode <= 10) begin
         repeat ($urandom_range(1, 20)) append_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) append_byte(filler());
      end
      if (text_bytes.size() == 0) append_byte(filler());
   endtask

   initial begin
      int               phase;
      int               phase_start;
      fss_pkg::req_type w;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      cur_pattern = '0;
      cur_len = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty pattern straight after reset
      send_text("x", 1'b1);
      load_pattern(pack_chars("aB"), 5'd2);
      send_text("Ab", 1'b1);
      send_text("xab", 1'b1);
      send_text("a", 1'b1);
      // boundary hits, then chars after the pattern is used up
      send_text("-a_bz", 1'b1);
      // pattern changed in the middle of a text
      load_pattern(pack_chars("ab"), 5'd2);
      send_text("a", 1'b0);
      load_pattern(pack_chars("xb"), 5'd2);
      send_text("b", 1'b1);
      w.text_char = 8'hff;
      w.last_char = 1'b0;
      send_word(w);
      w.text_char = 8'h00;
      w.last_char = 1'b1;
      send_word(w);
      load_pattern(pack_chars("z@"), 5'd2);
      send_text("Z@", 1'b1);
      send_text("[z@", 1'b1);

      phase = 0;
      while (accepted_words < ITEM_TARGET) begin
         pick_config(phase);
         if (phase == 2) hold_request = 1'b1;
         phase_start = accepted_words;
         while (accepted_words - phase_start < PHASE_WORDS) begin
            make_text();
            send_bytes();
         end
         phase++;
      end

      @(negedge clock);
      req_push = 1'b0;
      draining = 1'b1;
      while (scorer.pending() != 0) @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (scorer.errors == 0) begin
         $display("PASS fuzzy_subsequence_scorer_core");
      end else begin
         $display("FAIL fuzzy_subsequence_scorer_core");
      end
      $finish;
   end

endmodule
